/* design/xph_pkg.sv */
`default_nettype none
package xph_pkg;

  localparam int WORD_W = 64;
  localparam int KEY_W  = 7;
  localparam logic [KEY_W-1:0] KEY_RESET = 7'd32;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_PROBE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_TRUNC = 2'd1,
    ST_DROP  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] stored_word;
    logic [WORD_W-1:0] probe_word;
    logic [WORD_W-1:0] xor_word;
    status_t           status;
    logic              last;
  } res_t;

  // clamp key_bits to 1..64
  function automatic logic [KEY_W-1:0] eff_keys(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    begin
      r = k;
      if (k == '0) r = 7'd1;
      else if (k > 7'd64) r = 7'd64;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* design/xph_mem.sv */
`default_nettype none
module xph_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [64:0]   wdata,
  output logic      [64:0]   rdata
);

  logic [64:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* design/xph_hash.sv */
`default_nettype none
module xph_hash #(
  parameter int TABLE_SIZE = 512,
  parameter int IDX_W      = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [63:0]      word,
  input  wire logic [6:0]       keff,
  output logic                  done,
  output logic [IDX_W-1:0]      slot
);

  localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  generate
    if (POW2) begin : gen_mask
      logic [6:0]  sh;
      logic [63:0] shifted;

      assign sh      = 7'd64 - keff;
      assign shifted = word >> sh;

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          slot <= shifted[IDX_W-1:0];
        end
      end
    end else begin : gen_recip
      // remainder 16 bits a step by reciprocal multiplication, msb chunk first
      localparam int          K     = 32 + IDX_W;
      localparam logic [15:0] SIZE  = 16'(TABLE_SIZE);
      localparam logic [32:0] RECIP =
        33'(((64'd1 << K) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
      logic        busy;
      logic        phase;
      logic [1:0]  chunk;
      logic [6:0]  sh;
      logic [63:0] x;
      logic [15:0] rem;
      logic [15:0] q;
      logic [31:0] y;
      logic [64:0] prod;
      logic [31:0] diff;

      assign sh   = 7'd64 - keff;
      assign y    = {rem, x[63:48]};
      assign prod = 65'(y) * 65'(RECIP);
      assign diff = y - 32'(q) * 32'(SIZE);
      assign slot = rem[IDX_W-1:0];

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
        end else if (start) begin
          busy <= 1'b1;
          done <= 1'b0;
        end else if (busy && phase && chunk == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
        if (start) begin
          x     <= word >> sh;
          rem   <= '0;
          chunk <= '0;
          phase <= 1'b0;
        end else if (busy) begin
          if (!phase) begin
            q     <= prod[K+15:K];
            phase <= 1'b1;
          end else begin
            rem   <= diff[15:0];
            x     <= {x[47:0], 16'd0};
            chunk <= chunk + 2'd1;
            phase <= 1'b0;
          end
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

/* design/xph_seq.sv */
`default_nettype none
module xph_seq #(
  parameter int TABLE_SIZE  = 512,
  parameter int MAX_MATCHES = 64,
  parameter int IDX_W       = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire xph_pkg::func_t   in_func,
  input  wire logic [63:0]      in_word,
  input  wire logic [6:0]       keff,
  output logic                  hash_start,
  input  wire logic             hash_done,
  input  wire logic [IDX_W-1:0] hash_slot,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_addr,
  output logic [64:0]           mem_wdata,
  input  wire logic [64:0]      mem_rdata,
  output logic                  res_push,
  input  wire logic             res_free,
  output xph_pkg::res_t         res
);
  import xph_pkg::*;

  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(MAX_MATCHES);

  state_t           state, state_next;
  func_t            op, op_next;
  logic [63:0]      word, word_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [IDX_W-1:0] walk, walk_next;
  logic [CNT_W-1:0] nmatch, nmatch_next;
  logic             pend_valid, pend_valid_next;
  res_t             pend, pend_next;

  logic             rd_valid;
  logic [63:0]      rd_word;
  logic [63:0]      hi_mask;
  logic             hit;
  logic             wrap;
  logic [IDX_W-1:0] slot_inc;

  assign rd_valid = mem_rdata[64];
  assign rd_word  = mem_rdata[63:0];
  assign hi_mask  = ~({64{1'b1}} >> keff);
  assign hit      = rd_valid && (((rd_word ^ word) & hi_mask) == 64'd0);
  assign wrap     = walk == LAST;
  assign slot_inc = (slot == LAST) ? '0 : slot + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      slot       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      slot       <= slot_next;
      pend_valid <= pend_valid_next;
    end
    op     <= op_next;
    word   <= word_next;
    walk   <= walk_next;
    nmatch <= nmatch_next;
    pend   <= pend_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    word_next       = word;
    slot_next       = slot;
    walk_next       = walk;
    nmatch_next     = nmatch;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    in_ready        = 1'b0;
    hash_start      = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = slot;
    mem_wdata       = {1'b1, word};
    res_push        = 1'b0;
    res             = pend;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (slot == LAST) begin
          slot_next  = '0;
          state_next = S_IDLE;
        end else begin
          slot_next = slot + IDX_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next   = in_func;
          word_next = in_word;
          case (in_func)
            FN_CLEAR: begin
              slot_next  = '0;
              state_next = S_INIT;
            end
            FN_INSERT, FN_PROBE: begin
              hash_start = 1'b1;
              state_next = S_HASH;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_next   = hash_slot;
          walk_next   = '0;
          nmatch_next = '0;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_CK;
      end
      S_CK: begin
        if (op == FN_INSERT) begin
          if (!rd_valid) begin
            mem_we     = 1'b1;
            state_next = S_IDLE;
          end else if (wrap) begin
            pend_next       = '{stored_word: '0, probe_word: word, xor_word: '0,
                                status: ST_DROP, last: 1'b1};
            pend_valid_next = 1'b1;
            state_next      = S_FIN;
          end else begin
            slot_next  = slot_inc;
            walk_next  = walk + IDX_W'(1);
            state_next = S_RD;
          end
        end else begin
          if (!rd_valid) begin
            state_next = S_FIN;
          end else if (hit) begin
            if (nmatch == CAP) begin
              pend_next.status = ST_TRUNC;
              state_next       = S_FIN;
            end else if (!pend_valid || res_free) begin
              // older match leaves as the new one takes its place
              res_push        = pend_valid;
              pend_next       = '{stored_word: rd_word, probe_word: word,
                                  xor_word: rd_word ^ word, status: ST_MATCH,
                                  last: 1'b0};
              pend_valid_next = 1'b1;
              nmatch_next     = nmatch + CNT_W'(1);
              if (wrap) begin
                state_next = S_FIN;
              end else begin
                slot_next  = slot_inc;
                walk_next  = walk + IDX_W'(1);
                state_next = S_RD;
              end
            end
          end else if (wrap) begin
            state_next = S_FIN;
          end else begin
            slot_next  = slot_inc;
            walk_next  = walk + IDX_W'(1);
            state_next = S_RD;
          end
        end
      end
      S_FIN: begin
        res.last = 1'b1;
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (res_free) begin
          res_push        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_free)
    else $error("result pushed into a full output register");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("item taken while a result is pending");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_CK || state == S_FIN) |-> nmatch <= CAP)
    else $error("match count above cap");

  a_hash_wait: assert property (@(posedge clk) disable iff (rst)
    hash_start |=> state == S_HASH)
    else $error("hash started outside the hash step");

endmodule
`default_nettype wire

/* design/xor_prefix_hash_join.sv */
// channel  dir  handshake         payload
// s        in   s_tvalid/tready   tdata: word; tuser: func
// m        out  m_tvalid/tready   tdata: stored, probe, xor; tuser: status; tlast: last
// cfg      in   cfg_we            cfg_wdata: key_bits
//
// insert/probe: hash takes the prefix's low bits for a power-of-two TABLE_SIZE, else
// runs on the reciprocal remainder unit; then each slot visited takes a memory
// read, then a check. clear: sweeps every slot of the table memory.
// after reset a clearing pass over the table runs before s_tready rises.
// a full output register holds the walk until m_tready frees it.
`default_nettype none
module xor_prefix_hash_join #(
  parameter int TABLE_SIZE  = 512,
  parameter int MAX_MATCHES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,   // key_bits
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,     // word
  input  wire logic [1:0]   s_tuser,     // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [191:0]      m_tdata,     // stored_word, probe_word, xor_word
  output logic [1:0]        m_tuser,     // status
  output logic              m_tlast      // last
);
  import xph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic [KEY_W-1:0] key_bits;
  logic [KEY_W-1:0] keff;
  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] hash_slot;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [64:0]      mem_wdata;
  logic [64:0]      mem_rdata;
  logic             res_push;
  logic             res_free;
  res_t             res;
  res_t             o_res;
  logic             o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits <= KEY_RESET;
    end else if (cfg_we) begin
      key_bits <= cfg_wdata;
    end
  end

  assign keff = eff_keys(key_bits);

  xph_seq #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_MATCHES(MAX_MATCHES),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (func_t'(s_tuser)),
    .in_word   (s_tdata),
    .keff      (keff),
    .hash_start(hash_start),
    .hash_done (hash_done),
    .hash_slot (hash_slot),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_push  (res_push),
    .res_free  (res_free),
    .res       (res)
  );

  xph_hash #(
    .TABLE_SIZE(TABLE_SIZE),
    .IDX_W     (IDX_W)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .word (s_tdata),
    .keff (keff),
    .done (hash_done),
    .slot (hash_slot)
  );

  xph_mem #(
    .DEPTH(TABLE_SIZE),
    .AW   (IDX_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // output register
  assign res_free = !o_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (res_push) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
    if (res_push) begin
      o_res <= res;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_res.xor_word, o_res.probe_word, o_res.stored_word};
  assign m_tuser  = o_res.status;
  assign m_tlast  = o_res.last;

endmodule
`default_nettype wire

/* sim/xor_prefix_hash_join_tb.sv */
`timescale 1ns / 100ps
module xor_prefix_hash_join_tb;
  import xph_pkg::*;

  localparam int SLOTS = 512;
  localparam int MATCH_CAP = 64;
  localparam int WALK_SETTLE = 2 * SLOTS + 200;
  localparam int STALL_LIMIT = 20000;
  localparam int REPORT_CAP = 40;
  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

  class join_scoreboard;
    logic [WORD_W-1:0] slot_word [SLOTS];
    bit slot_used [SLOTS];
    logic [KEY_W-1:0] key_bits;
    res_t match_q[$];
    int errors;

    function new();
      key_bits = KEY_RESET;
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
        slot_word[i] = '0;
        slot_used[i] = 1'b0;
      end
    endfunction

    // key_bits clamped to 1..64, returned as the shift that leaves the prefix
    function int unsigned hash_shift();
      int unsigned k;
      k = key_bits;
      if (k < 1) k = 1;
      else if (k > 64) k = 64;
      return 64 - k;
    endfunction

    function void note_item(func_t fn, logic [WORD_W-1:0] w);
      int unsigned sh;
      int unsigned s;
      int n;
      logic [WORD_W-1:0] z;
      res_t r;
      res_t hits [MATCH_CAP];
      sh = hash_shift();
      s = int'((w >> sh) % SLOTS);
      n = 0;
      case (fn)
        FN_CLEAR: clear_table();
        FN_INSERT: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              slot_word[s] = w;
              return;
            end
            s = (s + 1) % SLOTS;
          end
          // table full, item dropped
          r.stored_word = '0;
          r.probe_word = w;
          r.xor_word = '0;
          r.status = ST_DROP;
          r.last = 1'b1;
          match_q.push_back(r);
        end
        FN_PROBE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[s]) break;
            z = slot_word[s] ^ w;
            if ((z >> sh) == 0) begin
              if (n == MATCH_CAP) begin
                hits[n-1].status = ST_TRUNC;
                break;
              end
              hits[n].stored_word = slot_word[s];
              hits[n].probe_word = w;
              hits[n].xor_word = z;
              hits[n].status = ST_MATCH;
              hits[n].last = 1'b0;
              n++;
            end
            s = (s + 1) % SLOTS;
          end
          if (n > 0) hits[n-1].last = 1'b1;
          for (int j = 0; j < n; j++) match_q.push_back(hits[j]);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [191:0] data, logic [1:0] user, logic lastb);
      res_t got;
      res_t want;
      got.stored_word = data[63:0];
      got.probe_word = data[127:64];
      got.xor_word = data[191:128];
      got.status = status_t'(user);
      got.last = lastb;
      if (match_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result stored %h probe %h xor %h status %0d last %0d",
                   $time, got.stored_word, got.probe_word, got.xor_word, got.status,
                   got.last);
        return;
      end
      want = match_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t: expected stored %h probe %h xor %h status %0d last %0d",
                   $time, want.stored_word, want.probe_word, want.xor_word, want.status,
                   want.last);
          $display("%0t:   actual stored %h probe %h xor %h status %0d last %0d",
                   $time, got.stored_word, got.probe_word, got.xor_word, got.status,
                   got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [KEY_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [WORD_W-1:0] s_tdata = '0;   // word
  logic [1:0] s_tuser = '0;          // func
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [191:0] m_tdata;             // stored_word, probe_word, xor_word
  logic [1:0] m_tuser;               // status
  logic m_tlast;                     // last

  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  join_scoreboard sb;

  xor_prefix_hash_join DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // keep the hashed prefix, randomize the bits below it
  function automatic logic [WORD_W-1:0] near_word(logic [WORD_W-1:0] prefix);
    logic [WORD_W-1:0] keep;
    keep = ~(ONES >> (64 - sb.hash_shift()));
    return (prefix & keep) | (rand_word() & ~keep);
  endfunction

  task automatic send_item(func_t fn, logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_item(fn, w);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.match_q.size() != 0) @(posedge clk);
    repeat (WALK_SETTLE) @(posedge clk);
  endtask

  task automatic write_key(logic [KEY_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key_bits = v;
  endtask

  task automatic run_phase(int key, int s_idle, int r_stall, int items, int pool_size);
    logic [WORD_W-1:0] pool[$];
    logic [WORD_W-1:0] w;
    int pick;
    write_key(KEY_W'(key));
    send_idle = s_idle;
    recv_stall = r_stall;
    pool = {};
    repeat (pool_size) begin
      pick = $urandom_range(9);
      if (pick == 0) pool.push_back('0);
      else if (pick == 1) pool.push_back(ONES);
      else pool.push_back(rand_word());
    end
    send_item(FN_CLEAR, rand_word());
    repeat (items) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) < 8) w = near_word(pool[$urandom_range(pool_size - 1)]);
      else w = rand_word();
      if (pick < 55) send_item(FN_INSERT, w);
      else if (pick < 94) send_item(FN_PROBE, w);
      else if (pick < 97) send_item(FN_CLEAR, w);
      else send_item(FN_NONE, w);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, key_bits at reset value
    send_item(FN_PROBE, ONES);
    send_item(FN_NONE, ONES);
    send_item(FN_INSERT, '0);
    send_item(FN_PROBE, '0);
    send_item(FN_INSERT, ONES);
    send_item(FN_INSERT, 64'hFFFF_FFFF_0000_0000);
    send_item(FN_PROBE, 64'hFFFF_FFFF_1234_5678);
    send_item(FN_INSERT, 64'h1234_5678_0000_0001);
    send_item(FN_INSERT, 64'h1234_5678_8000_0000);
    send_item(FN_PROBE, 64'h1234_5679_0000_0001);
    send_item(FN_PROBE, 64'h1234_5678_FFFF_FFFF);
    send_item(FN_NONE, '0);
    send_item(FN_CLEAR, ONES);
    send_item(FN_PROBE, ONES);
    send_item(FN_INSERT, 64'hA5A5_5A5A_0F0F_F0F0);
    send_item(FN_PROBE, 64'hA5A5_5A5A_F0F0_0F0F);

    run_phase(8, 0, 0, 60, 4);
    run_phase(1, 47, 0, 170, 1);
    run_phase(64, 0, 47, 60, 3);
    run_phase(0, 7, 7, 60, 2);
    run_phase(127, 47, 0, 50, 3);
    run_phase(20, 0, 47, 50, 3);

    drain();
    if (sb.errors == 0 && sb.match_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
design/xph_pkg.sv
design/xph_mem.sv
design/xph_hash.sv
design/xph_seq.sv
design/xor_prefix_hash_join.sv
sim/xor_prefix_hash_join_tb.sv
